@@ design/cwt_pkg.sv @@
// ----------------------------------------------------------------------------
// cwt_pkg
// Types and constants shared by the word tokenizer modules.
// ----------------------------------------------------------------------------
package cwt_pkg;

  // Scanner modes.
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_IDENT   = 3'd1;
  localparam logic [2:0] MODE_QUOTE   = 3'd2;
  localparam logic [2:0] MODE_ESCAPE  = 3'd3;
  localparam logic [2:0] MODE_SLASH   = 3'd4;
  localparam logic [2:0] MODE_COMMENT = 3'd5;
  localparam logic [2:0] MODE_STAR    = 3'd6;

  // Word kinds.
  localparam logic [1:0] KIND_IDENT  = 2'd0;
  localparam logic [1:0] KIND_QUOTED = 2'd1;
  localparam logic [1:0] KIND_SINGLE = 2'd2;

  // Characters with a special meaning.
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  localparam logic [7:0] MAX_CHARS_RESET = 8'd99;

  // Output queue: up to two writes and one read per cycle.
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = 2;
  localparam int OUTQ_CNT_W = 3;

  typedef struct packed {
    logic [2:0] mode;
    logic       quote_is_double;
    logic [7:0] held_char;
    logic       held_valid;
    logic [7:0] word_length;
  } scan_state_t;

  typedef struct packed {
    logic [7:0] word_char;
    logic [1:0] word_kind;
    logic       last;
  } word_beat_t;

  typedef struct packed {
    word_beat_t  beat0;
    word_beat_t  beat1;
    logic [1:0]  num_beats;
    scan_state_t state_next;
  } step_result_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_ident_tail(input logic [7:0] c);
    return is_letter(c) || ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_UNDER);
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

endpackage

@@ design/cwt_step.sv @@
// ----------------------------------------------------------------------------
// cwt_step
// One scanner step: from the current state and one byte, the next state and
// up to two word beats, packed to the front.
// ----------------------------------------------------------------------------
module cwt_step import cwt_pkg::*; (
  input  scan_state_t  state,
  input  logic [7:0]   max_word_chars,
  input  logic [7:0]   character,
  input  logic         end_of_input,
  output step_result_t result
);

  logic [7:0]  limit;
  logic        full;
  logic [1:0]  held_kind;
  word_beat_t  held_mid;
  word_beat_t  held_end;
  logic        quote_match;

  scan_state_t sw_state;
  logic        sw_emit;
  word_beat_t  char_single;
  word_beat_t  slash_single;

  scan_state_t nxt;
  logic        e0_v;
  logic        e1_v;
  word_beat_t  e0;
  word_beat_t  e1;

  assign limit        = (max_word_chars == 8'd0) ? 8'd1 : max_word_chars;
  assign full         = state.word_length >= limit;
  assign held_kind    = (state.mode == MODE_IDENT) ? KIND_IDENT : KIND_QUOTED;
  assign held_mid     = '{word_char: state.held_char, word_kind: held_kind, last: 1'b0};
  assign held_end     = '{word_char: state.held_char, word_kind: held_kind, last: 1'b1};
  assign char_single  = '{word_char: character, word_kind: KIND_SINGLE, last: 1'b1};
  assign slash_single = '{word_char: CH_SLASH, word_kind: KIND_SINGLE, last: 1'b1};
  assign quote_match  = character == (state.quote_is_double ? CH_DQUOTE : CH_SQUOTE);

  // The byte taken as the start of a new word, after any open word is closed.
  always_comb begin
    sw_state             = state;
    sw_state.mode        = MODE_IDLE;
    sw_state.held_valid  = 1'b0;
    sw_state.word_length = 8'd0;
    sw_emit              = 1'b0;
    if (is_blank(character)) begin
      sw_emit = 1'b0;
    end else if (is_letter(character) || character == CH_HASH || character == CH_UNDER) begin
      sw_state.held_char   = character;
      sw_state.held_valid  = 1'b1;
      sw_state.word_length = 8'd1;
      sw_state.mode        = MODE_IDENT;
    end else if (character == CH_DQUOTE || character == CH_SQUOTE) begin
      sw_state.held_char       = character;
      sw_state.held_valid      = 1'b1;
      sw_state.word_length     = 8'd1;
      sw_state.quote_is_double = (character == CH_DQUOTE);
      sw_state.mode            = MODE_QUOTE;
    end else if (character == CH_SLASH) begin
      sw_state.mode = MODE_SLASH;
    end else begin
      sw_emit = 1'b1;
    end
  end

  always_comb begin
    nxt  = state;
    e0_v = 1'b0;
    e1_v = 1'b0;
    e0   = held_mid;
    e1   = char_single;
    if (end_of_input) begin
      nxt.mode        = MODE_IDLE;
      nxt.held_valid  = 1'b0;
      nxt.word_length = 8'd0;
      if (state.mode == MODE_IDENT || state.mode == MODE_QUOTE ||
          state.mode == MODE_ESCAPE) begin
        e0_v = state.held_valid;
        e0   = held_end;
      end else if (state.mode == MODE_SLASH) begin
        e0_v = 1'b1;
        e0   = slash_single;
      end
    end else begin
      unique case (state.mode)
        MODE_IDENT, MODE_QUOTE, MODE_ESCAPE: begin
          if ((state.mode == MODE_IDENT && (!is_ident_tail(character) || full)) ||
              (state.mode != MODE_IDENT && full)) begin
            // Close the open word and restart on this byte.
            e0_v = state.held_valid;
            e0   = held_end;
            e1_v = sw_emit;
            nxt  = sw_state;
          end else if (state.mode == MODE_QUOTE && quote_match) begin
            // Closing quote: the held byte and the quote both go out.
            e0_v            = state.held_valid;
            e1_v            = 1'b1;
            e1              = '{word_char: character, word_kind: KIND_QUOTED, last: 1'b1};
            nxt.held_char   = character;
            nxt.held_valid  = 1'b0;
            nxt.word_length = 8'd0;
            nxt.mode        = MODE_IDLE;
          end else begin
            e0_v            = state.held_valid;
            nxt.held_char   = character;
            nxt.held_valid  = 1'b1;
            nxt.word_length = state.word_length + 8'd1;
            if (state.mode == MODE_ESCAPE) begin
              nxt.mode = MODE_QUOTE;
            end else if (state.mode == MODE_QUOTE && character == CH_BSLASH) begin
              nxt.mode = MODE_ESCAPE;
            end
          end
        end
        MODE_SLASH: begin
          if (character == CH_STAR) begin
            nxt.mode = MODE_COMMENT;
          end else begin
            e0_v = 1'b1;
            e0   = slash_single;
            e1_v = sw_emit;
            nxt  = sw_state;
          end
        end
        MODE_COMMENT: begin
          if (character == CH_STAR) begin
            nxt.mode = MODE_STAR;
          end
        end
        MODE_STAR: begin
          if (character == CH_SLASH) begin
            nxt.mode = MODE_IDLE;
          end else if (character != CH_STAR) begin
            nxt.mode = MODE_COMMENT;
          end
        end
        default: begin
          e1_v = sw_emit;
          nxt  = sw_state;
        end
      endcase
    end
  end

  always_comb begin
    result.state_next = nxt;
    if (e0_v) begin
      result.beat0     = e0;
      result.beat1     = e1;
      result.num_beats = e1_v ? 2'd2 : 2'd1;
    end else begin
      result.beat0     = e1;
      result.beat1     = e1;
      result.num_beats = e1_v ? 2'd1 : 2'd0;
    end
  end

endmodule

@@ design/cwt_outq.sv @@
// ----------------------------------------------------------------------------
// cwt_outq
// Small output queue that takes up to two beats per cycle and hands out one.
// ----------------------------------------------------------------------------
module cwt_outq import cwt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [1:0] push_count,
  input  word_beat_t push0,
  input  word_beat_t push1,
  input  logic       pop,
  output logic       has_room,
  output logic       not_empty,
  output word_beat_t head
);

  word_beat_t             entries [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0]  wr_ptr;
  logic [OUTQ_PTR_W-1:0]  rd_ptr;
  logic [OUTQ_CNT_W-1:0]  count;
  logic [OUTQ_PTR_W-1:0]  wr_ptr_plus1;

  assign wr_ptr_plus1 = wr_ptr + OUTQ_PTR_W'(1);
  assign has_room     = count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
  assign not_empty    = count != '0;
  assign head         = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      entries[wr_ptr_plus1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUTQ_PTR_W'(push_count);
      rd_ptr <= rd_ptr + OUTQ_PTR_W'(pop);
      count  <= count + OUTQ_CNT_W'(push_count) - OUTQ_CNT_W'(pop);
    end
  end

endmodule

@@ design/c_word_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// c_word_tokenizer_core
// Splits a stream of source bytes into identifiers, quoted constants and
// single-character words, skipping whitespace and comments.
// ----------------------------------------------------------------------------
// A byte is registered at the input and scanned from that register; its beats
// go into the four-entry output queue, which drives the output.
// Throughput: one byte per cycle while the queue has room for two beats; each
// byte gives zero to two beats, so the output rate sets the sustained figure.
// Reset: rst clears the scanner to idle, empties the queue and sets
// max_word_chars to 99.
module c_word_tokenizer_core import cwt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] character,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] word_char,
  output logic [1:0] word_kind,
  output logic       last
);

  logic         [7:0] max_word_chars;
  scan_state_t        state;
  logic               ireg_valid;
  logic         [7:0] ireg_char;
  logic               ireg_eoi;
  logic               q_room;
  logic               q_not_empty;
  word_beat_t         q_head;
  step_result_t       step;
  logic               do_step;

  assign do_step  = ireg_valid && q_room;
  assign in_ready = !ireg_valid || do_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_word_chars <= MAX_CHARS_RESET;
    end else if (cfg_wr_en) begin
      max_word_chars <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ireg_valid <= 1'b0;
    end else if (in_ready) begin
      ireg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ireg_char <= character;
      ireg_eoi  <= end_of_input;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{mode: MODE_IDLE, quote_is_double: 1'b0, held_char: 8'd0,
                 held_valid: 1'b0, word_length: 8'd0};
    end else if (do_step) begin
      state <= step.state_next;
    end
  end

  cwt_step u_step (
    .state          (state),
    .max_word_chars (max_word_chars),
    .character      (ireg_char),
    .end_of_input   (ireg_eoi),
    .result         (step)
  );

  cwt_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_count (do_step ? step.num_beats : 2'd0),
    .push0      (step.beat0),
    .push1      (step.beat1),
    .pop        (q_not_empty && out_ready),
    .has_room   (q_room),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  assign out_valid = q_not_empty;
  assign word_char = q_head.word_char;
  assign word_kind = q_head.word_kind;
  assign last      = q_head.last;

endmodule

@@ bench/c_word_tokenizer_core_tb.sv @@
// ----------------------------------------------------------------------------
// c_word_tokenizer_core_tb
// Self-checking bench for the word tokenizer. A short table of source bytes
// walks every scanner mode, then random identifiers, quoted constants,
// comments, whitespace and noise bytes follow under several word-length
// limits. Every output beat is checked against a behavioral tokenizer kept in
// the bench, with random gaps on the input side and stalls on the output side.
// ----------------------------------------------------------------------------
module c_word_tokenizer_core_tb;
  import cwt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 600000;
  localparam int PHASE_WORDS = 225;
  localparam int NUM_PHASES = 8;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       typed;
    logic [1:0] n;
    word_beat_t b0;
    word_beat_t b1;
  } dir_row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } src_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] character = 8'd0;
  logic       end_of_input = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] word_char;
  logic [1:0] word_kind;
  logic       last;

  // Tokenizer state as the bench sees it.
  logic [2:0] tk_mode = MODE_IDLE;
  logic       tk_dquote = 1'b0;
  logic [7:0] tk_held = 8'd0;
  logic       tk_held_ok = 1'b0;
  logic [7:0] tk_len = 8'd0;
  logic [7:0] word_limit = MAX_CHARS_RESET;

  word_beat_t step_beats[$];
  word_beat_t expected_beats[$];
  dir_row_t   dir_rows[$];
  src_byte_t  src_q[$];
  int         src_words;
  int         errors = 0;
  int         burst_left = 1;
  bit         no_gaps = 1'b0;
  bit         draining = 1'b0;
  int         rx_cycles = 0;
  int         rx_style = 0;

  c_word_tokenizer_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .character    (character),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .word_char    (word_char),
    .word_kind    (word_kind),
    .last         (last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- tokenizer
  function automatic bit alpha_byte(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit name_byte(input logic [7:0] c);
    return alpha_byte(c) || (c >= "0" && c <= "9") || c == CH_UNDER;
  endfunction

  function automatic bit space_byte(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit word_at_limit();
    return tk_len >= ((word_limit == 8'd0) ? 8'd1 : word_limit);
  endfunction

  function automatic logic [1:0] held_kind();
    return (tk_mode == MODE_IDENT) ? KIND_IDENT : KIND_QUOTED;
  endfunction

  task automatic put_beat(input logic [7:0] c, input logic [1:0] kind, input logic lst);
    word_beat_t b;
    b = {c, kind, lst};
    step_beats.push_back(b);
  endtask

  task automatic end_word();
    if (tk_held_ok) put_beat(tk_held, held_kind(), 1'b1);
    tk_held_ok = 1'b0;
    tk_len = 8'd0;
    tk_mode = MODE_IDLE;
  endtask

  task automatic shift_in(input logic [7:0] c);
    if (tk_held_ok) put_beat(tk_held, held_kind(), 1'b0);
    tk_held = c;
    tk_held_ok = 1'b1;
    tk_len = tk_len + 8'd1;
  endtask

  task automatic open_word(input logic [7:0] c);
    tk_mode = MODE_IDLE;
    tk_held_ok = 1'b0;
    tk_len = 8'd0;
    if (space_byte(c)) begin
      // Whitespace starts nothing.
    end else if (alpha_byte(c) || c == CH_HASH || c == CH_UNDER) begin
      tk_held = c;
      tk_held_ok = 1'b1;
      tk_len = 8'd1;
      tk_mode = MODE_IDENT;
    end else if (c == CH_DQUOTE || c == CH_SQUOTE) begin
      tk_held = c;
      tk_held_ok = 1'b1;
      tk_len = 8'd1;
      tk_dquote = (c == CH_DQUOTE);
      tk_mode = MODE_QUOTE;
    end else if (c == CH_SLASH) begin
      tk_mode = MODE_SLASH;
    end else begin
      put_beat(c, KIND_SINGLE, 1'b1);
    end
  endtask

  // Works out the beats that one accepted input byte produces.
  task automatic tokenize_byte(input logic [7:0] c, input logic eoi);
    step_beats.delete();
    if (eoi) begin
      case (tk_mode)
        MODE_IDENT, MODE_QUOTE, MODE_ESCAPE: end_word();
        MODE_SLASH: put_beat(CH_SLASH, KIND_SINGLE, 1'b1);
        default: ;
      endcase
      tk_mode = MODE_IDLE;
      tk_held_ok = 1'b0;
      tk_len = 8'd0;
    end else begin
      case (tk_mode)
        MODE_IDENT: begin
          if (name_byte(c) && !word_at_limit()) begin
            shift_in(c);
          end else begin
            end_word();
            open_word(c);
          end
        end
        MODE_QUOTE: begin
          if (word_at_limit()) begin
            end_word();
            open_word(c);
          end else if (c == (tk_dquote ? CH_DQUOTE : CH_SQUOTE)) begin
            shift_in(c);
            end_word();
          end else begin
            shift_in(c);
            if (c == CH_BSLASH) tk_mode = MODE_ESCAPE;
          end
        end
        MODE_ESCAPE: begin
          if (word_at_limit()) begin
            end_word();
            open_word(c);
          end else begin
            shift_in(c);
            tk_mode = MODE_QUOTE;
          end
        end
        MODE_SLASH: begin
          if (c == CH_STAR) begin
            tk_mode = MODE_COMMENT;
          end else begin
            put_beat(CH_SLASH, KIND_SINGLE, 1'b1);
            open_word(c);
          end
        end
        MODE_COMMENT: begin
          if (c == CH_STAR) tk_mode = MODE_STAR;
        end
        MODE_STAR: begin
          if (c == CH_SLASH) tk_mode = MODE_IDLE;
          else if (c != CH_STAR) tk_mode = MODE_COMMENT;
        end
        default: open_word(c);
      endcase
    end
  endtask

  // ------------------------------------------------------------------ sending
  // Called at a rising edge; returns at the edge where the byte is taken.
  task automatic push_byte(input logic [7:0] c, input logic eoi, input logic typed,
                           input logic [1:0] n, input word_beat_t b0, input word_beat_t b1);
    in_valid <= 1'b1;
    character <= c;
    end_of_input <= eoi;
    do @(posedge clk); while (!in_ready);
    tokenize_byte(c, eoi);
    if (typed) begin
      if (n > 2'd0) expected_beats.push_back(b0);
      if (n > 2'd1) expected_beats.push_back(b1);
    end else begin
      foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
    end
  endtask

  task automatic paced_send(input src_byte_t s);
    push_byte(s.ch, s.eoi, 1'b0, 2'd0, '0, '0);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      no_gaps = ($urandom_range(0, 3) == 0);
      if (!no_gaps) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  task automatic set_word_limit(input logic [7:0] v);
    while (expected_beats.size() != 0) @(posedge clk);
    // Bytes that give no beat may still be in the pipeline.
    repeat (6) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    word_limit = v;
  endtask

  // -------------------------------------------------------------- generation
  task automatic queue_src(input logic [7:0] c, input logic eoi);
    src_byte_t s;
    s = {c, eoi};
    src_q.push_back(s);
    src_words++;
  endtask

  function automatic int pick_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 6);
    return $urandom_range(1, int'(word_limit) + 2);
  endfunction

  task automatic gen_token();
    int pick;
    int len;
    logic [7:0] q;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      case ($urandom_range(0, 3))
        0: c = CH_HASH;
        1: c = CH_UNDER;
        2: c = 8'h41 + 8'($urandom_range(0, 25));
        default: c = 8'h61 + 8'($urandom_range(0, 25));
      endcase
      queue_src(c, 1'b0);
      len = pick_len() - 1;
      repeat (len) begin
        case ($urandom_range(0, 3))
          0: c = 8'h30 + 8'($urandom_range(0, 9));
          1: c = CH_UNDER;
          2: c = 8'h41 + 8'($urandom_range(0, 25));
          default: c = 8'h61 + 8'($urandom_range(0, 25));
        endcase
        queue_src(c, 1'b0);
      end
      if ($urandom_range(0, 1) == 1) queue_src(8'h20, 1'b0);
    end else if (pick < 50) begin
      q = ($urandom_range(0, 1) == 1) ? CH_DQUOTE : CH_SQUOTE;
      queue_src(q, 1'b0);
      len = pick_len();
      repeat (len) begin
        if ($urandom_range(0, 5) == 0) begin
          queue_src(CH_BSLASH, 1'b0);
          queue_src(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          c = 8'($urandom_range(0, 255));
          if (c == q) c = 8'h2E;
          queue_src(c, 1'b0);
        end
      end
      // Now and then the constant is left open for whatever follows.
      if ($urandom_range(0, 7) != 0) queue_src(q, 1'b0);
    end else if (pick < 60) begin
      queue_src(CH_SLASH, 1'b0);
      queue_src(CH_STAR, 1'b0);
      repeat ($urandom_range(0, 12)) queue_src(8'($urandom_range(0, 255)), 1'b0);
      repeat ($urandom_range(1, 3)) queue_src(CH_STAR, 1'b0);
      queue_src(CH_SLASH, 1'b0);
    end else if (pick < 70) begin
      repeat ($urandom_range(1, 3)) begin
        c = 8'($urandom_range(8, 13));
        queue_src((c == 8'h08) ? 8'h20 : c, 1'b0);
      end
    end else if (pick < 80) begin
      if ($urandom_range(0, 1) == 1) queue_src(CH_SLASH, 1'b0);
      else queue_src(8'($urandom_range(8'h21, 8'h2F)), 1'b0);
    end else if (pick < 96) begin
      repeat ($urandom_range(1, 4)) queue_src(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      queue_src(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic add_row(input logic [7:0] ch, input logic eoi, input logic typed,
                         input logic [1:0] n, input word_beat_t b0);
    dir_row_t r;
    r = {ch, eoi, typed, n, b0, word_beat_t'('0)};
    dir_rows.push_back(r);
  endtask

  // ---------------------------------------------------------------- checking
  task automatic note_mismatch(input string field, input int want, input int got);
    errors++;
    if (errors < 50)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, field, want, got);
  endtask

  always @(posedge clk) begin : rx_side
    word_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        errors++;
        if (errors < 50)
          $display("%0t: unexpected beat, expected none, actual char %0h kind %0d last %0b",
                   $realtime, word_char, word_kind, last);
      end else begin
        want = expected_beats.pop_front();
        if (word_char !== want.word_char) note_mismatch("word_char", want.word_char, word_char);
        if (word_kind !== want.word_kind) note_mismatch("word_kind", want.word_kind, word_kind);
        if (last !== want.last) note_mismatch("last", want.last, last);
      end
    end
    rx_cycles <= rx_cycles + 1;
    if (rx_cycles % 64 == 0) rx_style <= $urandom_range(0, 3);
    if (draining) begin
      out_ready <= 1'b1;
    end else begin
      case (rx_style)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (rx_cycles % 7 != 3);
      endcase
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------- stimulus
  initial begin : main
    logic [7:0] limits[NUM_PHASES];
    dir_row_t r;
    limits[0] = 8'd1;
    limits[1] = 8'd255;
    limits[2] = 8'd2;
    limits[3] = 8'd5;
    limits[4] = 8'($urandom_range(1, 16));
    limits[5] = 8'($urandom_range(1, 255));
    limits[6] = 8'd3;
    limits[7] = MAX_CHARS_RESET;

    // Right after reset, the byte extremes are one-character words.
    add_row("+", 1'b0, 1'b1, 2'd1, {8'h2B, KIND_SINGLE, 1'b1});
    add_row(8'h00, 1'b0, 1'b1, 2'd1, {8'h00, KIND_SINGLE, 1'b1});
    add_row(8'hFF, 1'b0, 1'b1, 2'd1, {8'hFF, KIND_SINGLE, 1'b1});
    add_row(" ", 1'b0, 1'b1, 2'd0, '0);
    add_row("a", 1'b0, 1'b0, 2'd0, '0);
    add_row(CH_UNDER, 1'b0, 1'b0, 2'd0, '0);
    add_row("9", 1'b0, 1'b0, 2'd0, '0);
    add_row(8'h09, 1'b0, 1'b0, 2'd0, '0);
    add_row(CH_HASH, 1'b0, 1'b0, 2'd0, '0);
    add_row(8'h0D, 1'b0, 1'b0, 2'd0, '0);
    add_row(CH_DQUOTE, 1'b0, 1'b0, 2'd0, '0);
    add_row(CH_BSLASH, 1'b0, 1'b0, 2'd0, '0);
    add_row(CH_DQUOTE, 1'b0, 1'b0, 2'd0, '0);
    add_row(CH_DQUOTE, 1'b0, 1'b0, 2'd0, '0);
    add_row(CH_SQUOTE, 1'b0, 1'b0, 2'd0, '0);
    add_row("x", 1'b0, 1'b0, 2'd0, '0);
    // End of input closes the open constant on its held character.
    add_row(8'hA5, 1'b1, 1'b1, 2'd1, {8'h78, KIND_QUOTED, 1'b1});
    add_row(CH_SLASH, 1'b0, 1'b0, 2'd0, '0);
    add_row("q", 1'b0, 1'b0, 2'd0, '0);
    add_row(CH_SLASH, 1'b0, 1'b0, 2'd0, '0);
    add_row(CH_STAR, 1'b0, 1'b0, 2'd0, '0);
    add_row(CH_STAR, 1'b0, 1'b0, 2'd0, '0);
    add_row(CH_STAR, 1'b0, 1'b0, 2'd0, '0);
    add_row(CH_SLASH, 1'b0, 1'b0, 2'd0, '0);
    add_row(CH_SLASH, 1'b0, 1'b0, 2'd0, '0);
    // A pending slash at end of input comes out as its own word.
    add_row(8'h5A, 1'b1, 1'b1, 2'd1, {CH_SLASH, KIND_SINGLE, 1'b1});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      push_byte(r.ch, r.eoi, r.typed, r.n, r.b0, r.b1);
    end
    in_valid <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_word_limit(limits[p]);
      src_words = 0;
      while (src_words < PHASE_WORDS) begin
        gen_token();
        while (src_q.size() != 0) paced_send(src_q.pop_front());
      end
      // Leave the scanner idle before the next register write.
      push_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0, 2'd0, '0, '0);
      in_valid <= 1'b0;
      @(posedge clk);
    end

    draining = 1'b1;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
